// ===== design/stq_pkg.sv =====
// Shared types and constants of the sorted timer queue.
package stq_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int TICK_W  = 32;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [ID_W-1:0]   timer_id_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam cmd_t CMD_SCHEDULE = 2'd0;
  localparam cmd_t CMD_DELETE   = 2'd1;
  localparam cmd_t CMD_QUERY    = 2'd2;
  localparam cmd_t CMD_TICK     = 2'd3;

  localparam logic KIND_ANSWER  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  // One result transaction.
  typedef struct packed {
    logic      kind;
    timer_id_t timer_id;
    logic      was_armed;
    logic      status;
    logic      have_next;
    tick_t     next_delay;
    logic      last;
  } res_t;

  // Flags of the shared subtract/compare unit.
  typedef struct packed {
    logic ge;
    logic gt;
  } cmp_t;

endpackage

// ===== design/stq_ifs.sv =====
// Command and result channel interfaces.
interface stq_req_if import stq_pkg::*;;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  logic [ID_W-1:0] timer_id;
  tick_t expiry;
  tick_t now_tick;

  modport source (output valid, cmd, timer_id, expiry, now_tick, input ready);
  modport sink   (input valid, cmd, timer_id, expiry, now_tick, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*;;
  logic  valid;
  logic  ready;
  logic  kind;
  logic [ID_W-1:0] out_timer_id;
  logic  was_armed;
  logic  status;
  logic  have_next;
  tick_t next_delay;
  logic  last;

  modport source (output valid, kind, out_timer_id, was_armed, status, have_next,
                  next_delay, last, input ready);
  modport sink   (input valid, kind, out_timer_id, was_armed, status, have_next,
                  next_delay, last, output ready);
endinterface

// ===== design/stq_alu.sv =====
// Shared 32-bit subtract and compare unit.
module stq_alu import stq_pkg::*; (
  input  tick_t a,
  input  tick_t b,
  output tick_t diff,
  output cmp_t  flags
);

  logic [TICK_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign diff     = wide[TICK_W-1:0];
  assign flags.ge = ~wide[TICK_W];
  assign flags.gt = ~wide[TICK_W] & (wide[TICK_W-1:0] != '0);

endmodule

// ===== design/stq_mem.sv =====
// Entry storage: one write port, one registered read port.
module stq_mem import stq_pkg::*; #(
  parameter int PW  = 5,
  parameter int IDW = 8
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [PW-1:0]  wr_addr,
  input  logic [IDW-1:0] wr_id,
  input  tick_t          wr_exp,
  input  logic           rd_en,
  input  logic [PW-1:0]  rd_addr,
  output logic [IDW-1:0] rd_id,
  output tick_t          rd_exp
);

  localparam int SLOTS = 1 << PW;

  logic [IDW-1:0] ids  [SLOTS];
  tick_t          exps [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]  <= wr_id;
      exps[wr_addr] <= wr_exp;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id  <= ids[rd_addr];
      rd_exp <= exps[rd_addr];
    end
  end

endmodule

// ===== design/stq_ctrl.sv =====
// Command sequencer: scans, shifts and pops the sorted ring entry by entry.
module stq_ctrl import stq_pkg::*; #(
  parameter int TIMERS = 32,
  parameter int IDW    = 8,
  parameter int PW     = 5,
  parameter int CW     = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  cmd_t           cmd,
  input  logic [IDW-1:0] timer_id,
  input  tick_t          expiry,
  input  tick_t          now_tick,
  output logic           idle,
  output logic           res_valid,
  output res_t           res,
  input  logic           res_take,
  output logic           wr_en,
  output logic [PW-1:0]  wr_addr,
  output logic [IDW-1:0] wr_id,
  output tick_t          wr_exp,
  output logic           rd_en,
  output logic [PW-1:0]  rd_addr,
  input  logic [IDW-1:0] rd_id,
  input  tick_t          rd_exp
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_ROUTE   = 4'd2;
  localparam logic [3:0] S_REM     = 4'd3;
  localparam logic [3:0] S_INS_RD  = 4'd4;
  localparam logic [3:0] S_INS_CMP = 4'd5;
  localparam logic [3:0] S_TICK    = 4'd6;
  localparam logic [3:0] S_POP_RD  = 4'd7;
  localparam logic [3:0] S_POP_CMP = 4'd8;
  localparam logic [3:0] S_FIN_RD  = 4'd9;
  localparam logic [3:0] S_FIN_OUT = 4'd10;

  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(TIMERS);

  logic [3:0]     state;
  cmd_t           cmd_r;
  logic [IDW-1:0] id_r;
  tick_t          exp_r;
  tick_t          now_r;
  tick_t          cur_tick;
  logic [PW-1:0]  head;
  logic [CW-1:0]  count;
  logic [CW-1:0]  scan;
  logic [CW-1:0]  chk_idx;
  logic           chk_vld;
  logic [CW-1:0]  hole;
  logic           found;
  logic           status_r;

  logic [CW-1:0]  rd_lidx;
  logic [CW-1:0]  wr_lidx;
  tick_t          alu_a;
  tick_t          alu_b;
  tick_t          diff;
  cmp_t           flags;
  logic           hit;
  logic           more;

  stq_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (diff),
    .flags (flags)
  );

  assign idle    = (state == S_IDLE);
  assign hit     = chk_vld && (rd_id == id_r);
  assign more    = (scan < count);
  assign rd_addr = head + rd_lidx[PW-1:0];
  assign wr_addr = head + wr_lidx[PW-1:0];

  always_comb begin
    rd_en     = 1'b0;
    rd_lidx   = '0;
    wr_en     = 1'b0;
    wr_lidx   = hole;
    wr_id     = id_r;
    wr_exp    = exp_r;
    alu_a     = rd_exp;
    alu_b     = cur_tick;
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      S_FIND: begin
        rd_en   = more;
        rd_lidx = scan;
      end
      S_REM: begin
        rd_en   = more;
        rd_lidx = scan;
        wr_en   = chk_vld;
        wr_lidx = chk_idx - ONE;
        wr_id   = rd_id;
        wr_exp  = rd_exp;
      end
      S_INS_RD: begin
        if (hole != '0) begin
          rd_en   = 1'b1;
          rd_lidx = hole - ONE;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        alu_b = exp_r;
        wr_en = 1'b1;
        if (flags.ge) begin
          wr_id  = rd_id;
          wr_exp = rd_exp;
          if (hole > ONE) begin
            rd_en   = 1'b1;
            rd_lidx = hole - CW'(2);
          end
        end
      end
      S_TICK: begin
        alu_a = now_r;
      end
      S_POP_RD, S_FIN_RD: begin
        rd_en = (count != '0);
      end
      S_POP_CMP: begin
        res_valid     = ~flags.gt;
        res.kind      = KIND_EXPIRED;
        res.timer_id  = ID_W'(rd_id);
        res.was_armed = 1'b1;
      end
      S_FIN_OUT: begin
        res_valid      = 1'b1;
        res.kind       = KIND_ANSWER;
        res.timer_id   = (cmd_r == CMD_TICK) ? '0 : ID_W'(id_r);
        res.was_armed  = found;
        res.status     = status_r;
        res.have_next  = (count != '0);
        res.next_delay = ((count != '0) && flags.gt) ? diff : '0;
        res.last       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      cur_tick <= '0;
      chk_vld  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            id_r     <= timer_id;
            exp_r    <= expiry;
            now_r    <= now_tick;
            found    <= 1'b0;
            status_r <= STATUS_OK;
            scan     <= '0;
            chk_vld  <= 1'b0;
            state    <= (cmd == CMD_TICK) ? S_TICK : S_FIND;
          end
        end
        S_FIND: begin
          if (hit) begin
            found <= 1'b1;
            state <= S_ROUTE;
          end else if (!more && !chk_vld) begin
            state <= S_ROUTE;
          end else begin
            chk_vld <= more;
            chk_idx <= scan;
            if (more) scan <= scan + ONE;
          end
        end
        S_ROUTE: begin
          chk_vld <= 1'b0;
          scan    <= chk_idx + ONE;
          hole    <= count;
          if ((cmd_r == CMD_QUERY) || (cmd_r == CMD_TICK)) begin
            state <= S_FIN_RD;
          end else if (found) begin
            state <= S_REM;
          end else if (cmd_r == CMD_DELETE) begin
            state <= S_FIN_RD;
          end else if (count == FULL) begin
            status_r <= STATUS_FULL;
            state    <= S_FIN_RD;
          end else begin
            state <= S_INS_RD;
          end
        end
        S_REM: begin
          if (!more && !chk_vld) begin
            count <= count - ONE;
            hole  <= count - ONE;
            state <= (cmd_r == CMD_SCHEDULE) ? S_INS_RD : S_FIN_RD;
          end else begin
            chk_vld <= more;
            chk_idx <= scan;
            if (more) scan <= scan + ONE;
          end
        end
        S_INS_RD: begin
          if (hole == '0) begin
            count <= count + ONE;
            state <= S_FIN_RD;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (flags.ge) begin
            hole <= hole - ONE;
            if (hole == ONE) state <= S_INS_RD;
          end else begin
            count <= count + ONE;
            state <= S_FIN_RD;
          end
        end
        S_TICK: begin
          if (flags.gt) cur_tick <= now_r;
          state <= S_POP_RD;
        end
        S_POP_RD: begin
          state <= (count == '0) ? S_FIN_OUT : S_POP_CMP;
        end
        S_POP_CMP: begin
          if (flags.gt) begin
            state <= S_FIN_OUT;
          end else if (res_take) begin
            head  <= head + PW'(1);
            count <= count - ONE;
            state <= S_POP_RD;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/sorted_timer_queue.sv =====
// Sorted timer queue top level: command intake, sequencer, entry memory, result register.
// Throughput: one command at a time; the entry memory (one read, one write port) is
//   walked one entry at a time by the sequencer.
// Reset (rst, synchronous): queue empty, current time zero, no clearing pass.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int TIMERS  = 32,
  parameter int ID_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  stq_req_if.sink   req,
  stq_rsp_if.source rsp
);

  // Stored handle width: only the low ID_BITS bits of a handle matter.
  localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  // Ring of slots: a power of two, so logical-to-physical wraps for free.
  localparam int PW  = $clog2(TIMERS);
  // Fill count and logical index, which must reach TIMERS itself.
  localparam int CW  = $clog2(TIMERS + 1);

  logic           idle;
  logic           res_valid;
  res_t           res;
  logic           res_take;
  logic           wr_en;
  logic [PW-1:0]  wr_addr;
  logic [IDW-1:0] wr_id;
  tick_t          wr_exp;
  logic           rd_en;
  logic [PW-1:0]  rd_addr;
  logic [IDW-1:0] rd_id;
  tick_t          rd_exp;

  logic out_valid;
  res_t out_res;

  // A command transaction is taken whenever the sequencer is idle, even while the
  // previous final result still sits in the output register.
  assign req.ready = idle;

  stq_ctrl #(
    .TIMERS (TIMERS),
    .IDW    (IDW),
    .PW     (PW),
    .CW     (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (req.valid && req.ready),
    .cmd       (req.cmd),
    .timer_id  (req.timer_id[IDW-1:0]),
    .expiry    (req.expiry),
    .now_tick  (req.now_tick),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_id     (wr_id),
    .wr_exp    (wr_exp),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_exp    (rd_exp)
  );

  stq_mem #(
    .PW  (PW),
    .IDW (IDW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .wr_exp  (wr_exp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_exp  (rd_exp)
  );

  // Output register: the sequencer hands over a result when the register is empty
  // or being drained this cycle; otherwise the sequencer waits in place.
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res <= res;
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_res.kind;
  assign rsp.out_timer_id = out_res.timer_id;
  assign rsp.was_armed    = out_res.was_armed;
  assign rsp.status       = out_res.status;
  assign rsp.have_next    = out_res.have_next;
  assign rsp.next_delay   = out_res.next_delay;
  assign rsp.last         = out_res.last;

endmodule

// ===== design/stq_check.sv =====
// Port-level checker for the sorted timer queue, bound to the top level.
module stq_check import stq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input logic      kind,
  input timer_id_t out_timer_id,
  input logic      was_armed,
  input logic      status,
  input logic      have_next,
  input tick_t     next_delay,
  input logic      last
);

  // Stalled result transaction holds.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_timer_id) && $stable(next_delay)
      && $stable(kind) && $stable(last))
    else $error("stalled result changed");

  // Expired report carries fixed flags and is never final.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == KIND_EXPIRED) |-> was_armed && !last && (status == STATUS_OK)
      && !have_next && (next_delay == '0))
    else $error("malformed expired report");

  // Every answer closes its command, and an empty queue has no delay.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == KIND_ANSWER) |-> last && (have_next || (next_delay == '0)))
    else $error("malformed final result");

  // The sequencer is busy right after it takes a command.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command taken while busy");

endmodule

bind sorted_timer_queue stq_check u_stq_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .kind         (rsp.kind),
  .out_timer_id (rsp.out_timer_id),
  .was_armed    (rsp.was_armed),
  .status       (rsp.status),
  .have_next    (rsp.have_next),
  .next_delay   (rsp.next_delay),
  .last         (rsp.last)
);
